// File: rtl/core/udpfr_pkg.sv
// udpfr_pkg: item types, header layout and result codes of the udp frame reassembler
// no dependencies; imported by udpfr_frame_ram and udp_frame_reassembler_unit

package udpfr_pkg;

    // default frame buffer size in bytes
    localparam int unsigned BUFFER_BYTES_DEF = 65536;

    // datagram header layout, big-endian byte offsets
    localparam int unsigned HEADER_BYTES = 20;
    localparam int unsigned HDR_FRAME    = 0;
    localparam int unsigned HDR_TOTAL    = 2;
    localparam int unsigned HDR_PAYLOAD  = 6;
    localparam int unsigned HDR_OFFSET   = 8;
    localparam int unsigned HDR_COUNT    = 12;
    localparam int unsigned HDR_INDEX    = 16;

    // frame number held before the first frame, position limit
    localparam logic [15:0] NO_FRAME = 16'hFFFF;
    localparam logic [15:0] POS_MAX  = 16'hFFFF;

    // input action codes
    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // result kind codes
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic        action;
        logic [7:0]  data_byte;
        logic        datagram_end;
        logic [15:0] read_address;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] frame_id;
        logic [31:0] byte_count;
        logic        frame_complete;
        logic        overflow_seen;
        logic [7:0]  read_byte;
    } out_item_t;

endpackage

// File: rtl/core/udp_frame_reassembler_unit.sv
// udp_frame_reassembler_unit: top level, header parsing, frame accounting, result queue
// depends on udpfr_pkg and udpfr_frame_ram

// Datagram bytes and buffer reads enter as items on the item channel, one item per cycle
// at full rate. A payload byte is written to the frame store in the cycle it is accepted;
// a buffer read looks up the store's single read port, whose registered data arrives in
// the next cycle. Read results and frame delivery reports are registered in the read stage
// and then pass through a three-entry result queue; the block takes new items while
// results wait there and stalls the item channel only when the queue and the read stage
// together hold three results. A read of a buffer byte that was never written returns an
// undefined value; there is no clearing pass after reset.

module udp_frame_reassembler_unit #(
    parameter int unsigned BUFFER_BYTES = udpfr_pkg::BUFFER_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  udpfr_pkg::in_item_t  item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output udpfr_pkg::out_item_t result
);
    import udpfr_pkg::*;

    localparam int unsigned ADDR_W    = $clog2(BUFFER_BYTES);
    localparam int unsigned RD_W      = ADDR_W + 16;
    localparam int unsigned HDR_IDX_W = $clog2(HEADER_BYTES);
    localparam int unsigned Q_DEPTH   = 3;
    localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // frame state
    logic [15:0] cur_frame_reg, cur_frame_next;
    logic [31:0] count_reg, count_next;
    logic [15:0] pos_reg, pos_next;
    logic        ovf_reg, ovf_next;
    logic [7:0]  hdr_reg [HEADER_BYTES];

    // read stage
    logic        b_valid_reg, b_valid_next;
    logic        b_kind_reg;
    logic        b_oor_reg;

    // result queue
    out_item_t           queue_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wptr_reg, rptr_reg;
    logic [Q_CNT_W-1:0]  cnt_reg, cnt_next;

    logic accept, take_byte, take_read;
    logic push, pop;

    // handshake
    assign accept    = item_valid && !item_stall;
    assign take_byte = accept && (item.action == ACT_DATA);
    assign take_read = accept && (item.action == ACT_READ);
    assign item_stall = ({1'b0, cnt_reg} + {{Q_CNT_W{1'b0}}, b_valid_reg})
                        >= (Q_CNT_W + 1)'(Q_DEPTH);

    // header fields
    logic [15:0] frame_num, pay_len;
    logic [31:0] total_size, pay_offset, pkt_count, pkt_index;
    assign frame_num  = {hdr_reg[HDR_FRAME], hdr_reg[HDR_FRAME + 1]};
    assign pay_len    = {hdr_reg[HDR_PAYLOAD], hdr_reg[HDR_PAYLOAD + 1]};
    assign total_size = {hdr_reg[HDR_TOTAL], hdr_reg[HDR_TOTAL + 1],
                         hdr_reg[HDR_TOTAL + 2], hdr_reg[HDR_TOTAL + 3]};
    assign pay_offset = {hdr_reg[HDR_OFFSET], hdr_reg[HDR_OFFSET + 1],
                         hdr_reg[HDR_OFFSET + 2], hdr_reg[HDR_OFFSET + 3]};
    assign pkt_count  = {hdr_reg[HDR_COUNT], hdr_reg[HDR_COUNT + 1],
                         hdr_reg[HDR_COUNT + 2], hdr_reg[HDR_COUNT + 3]};
    assign pkt_index  = {hdr_reg[HDR_INDEX], hdr_reg[HDR_INDEX + 1],
                         hdr_reg[HDR_INDEX + 2], hdr_reg[HDR_INDEX + 3]};

    // position decode
    logic                 pos_sat, in_header, header_last, dgram_full;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic [15:0]          ppos;
    assign pos_sat     = (pos_reg == POS_MAX);
    assign in_header   = (pos_reg < 16'(HEADER_BYTES));
    assign header_last = (pos_reg == 16'(HEADER_BYTES - 1));
    assign dgram_full  = (pos_reg >= 16'(HEADER_BYTES - 1));
    assign hdr_idx     = pos_reg[HDR_IDX_W-1:0];
    assign ppos        = pos_reg - 16'(HEADER_BYTES);

    // payload address and buffer bound
    logic        in_payload, wr_in_buf;
    logic [32:0] wr_addr_wide;
    assign in_payload   = !pos_sat && !in_header && (ppos < pay_len);
    assign wr_addr_wide = {1'b0, pay_offset} + {17'd0, ppos};
    assign wr_in_buf    = (wr_addr_wide < 33'(BUFFER_BYTES));

    logic ram_we;
    assign ram_we = take_byte && in_payload && wr_in_buf;

    // read address and buffer bound
    logic [RD_W-1:0] rd_wide;
    logic            rd_oor;
    assign rd_wide = {{ADDR_W{1'b0}}, item.read_address};
    assign rd_oor  = (rd_wide >= RD_W'(BUFFER_BYTES));

    // header completion: frame switch and saturating count
    logic        new_frame;
    logic [31:0] count_base;
    logic [32:0] count_sum;
    assign new_frame  = (frame_num != cur_frame_reg);
    assign count_base = new_frame ? 32'd0 : count_reg;
    assign count_sum  = {1'b0, count_base} + {17'd0, pay_len};

    // next frame state
    always_comb
    begin
        cur_frame_next = cur_frame_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        if (take_byte)
        begin
            if (header_last)
            begin
                cur_frame_next = frame_num;
                count_next     = count_sum[32] ? 32'hFFFF_FFFF : count_sum[31:0];
                if (new_frame)
                begin
                    ovf_next = 1'b0;
                end
            end
            if (in_payload && !wr_in_buf)
            begin
                ovf_next = 1'b1;
            end
            if (item.datagram_end)
            begin
                pos_next = 16'd0;
            end
            else if (!pos_sat)
            begin
                pos_next = pos_reg + 16'd1;
            end
        end
    end

    assign b_valid_next = take_read || (take_byte && item.datagram_end && dgram_full);

    // frame state and read stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_frame_reg <= NO_FRAME;
            count_reg     <= 32'd0;
            pos_reg       <= 16'd0;
            ovf_reg       <= 1'b0;
            b_valid_reg   <= 1'b0;
            for (int i = 0; i < HEADER_BYTES; i++)
            begin
                hdr_reg[i] <= 8'd0;
            end
        end
        else
        begin
            cur_frame_reg <= cur_frame_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            b_valid_reg   <= b_valid_next;
            if (take_byte && in_header)
            begin
                hdr_reg[hdr_idx] <= item.data_byte;
            end
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_kind_reg <= (item.action == ACT_READ) ? KIND_READ : KIND_REPORT;
            b_oor_reg  <= rd_oor;
        end
    end

    // frame buffer
    logic [7:0] ram_rdata;

    udpfr_frame_ram #(
        .DEPTH  (BUFFER_BYTES),
        .ADDR_W (ADDR_W)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr_wide[ADDR_W-1:0]),
        .wdata (item.data_byte),
        .re    (take_read),
        .raddr (rd_wide[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // result build: last packet check and completion against live frame state
    logic      last_packet;
    out_item_t b_item;
    assign last_packet = (pkt_index == (pkt_count - 32'd1));

    always_comb
    begin
        b_item = '0;
        b_item.result_kind = b_kind_reg;
        if (b_kind_reg == KIND_READ)
        begin
            b_item.read_byte = b_oor_reg ? 8'd0 : ram_rdata;
        end
        else
        begin
            b_item.frame_id       = cur_frame_reg;
            b_item.byte_count     = count_reg;
            b_item.frame_complete = (count_reg >= total_size);
            b_item.overflow_seen  = ovf_reg;
        end
    end

    assign push = b_valid_reg && ((b_kind_reg == KIND_READ) || last_packet);
    assign pop  = result_valid && !result_stall;

    // result queue control
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wptr_reg <= (wptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_reg + Q_PTR_W'(1);
            end
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wptr_reg] <= b_item;
        end
    end

    assign result_valid = (cnt_reg != '0);
    assign result       = queue_reg[rptr_reg];

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue count beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (cnt_reg < Q_CNT_W'(Q_DEPTH)))
        else $error("result pushed into a full queue");

    a_read_stage: assert property (@(posedge clk) disable iff (!rst_n)
        take_read |=> (b_valid_reg && (b_kind_reg == KIND_READ)))
        else $error("read item did not reach the read stage");

    a_end_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (take_byte && item.datagram_end) |=> (pos_reg == 16'd0))
        else $error("byte position not restarted after datagram end");

endmodule

// File: rtl/core/udpfr_frame_ram.sv
// udpfr_frame_ram: frame buffer, one write port and one read port, registered read data
// depends on udpfr_pkg for the default depth

module udpfr_frame_ram #(
    parameter int unsigned DEPTH  = udpfr_pkg::BUFFER_BYTES_DEF,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);
    import udpfr_pkg::*;

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rdata_reg;

    // byte write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    // registered byte read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
